[rtl/chh_pkg.sv]
// Shared types, constants and the byte classifier for the character class histogram.
package chh_pkg;

    localparam int NUM_BINS       = 37;
    localparam int OTHER_BIN      = 36;
    localparam int DIGIT_BASE     = 26;
    localparam int BIN_BITS       = 6;
    localparam int CHAR_BITS      = 8;
    localparam int OUT_CNT_BITS   = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int S_TDATA_BITS   = 8;
    localparam int M_TDATA_BITS   = 24;

    localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_READ,
        ST_EMIT,
        ST_EMPTY,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic count;
        logic sweep;
        logic idx_clr;
        logic idx_inc;
        logic load_bin;
        logic load_empty;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic any;
        logic bin_nz;
        logic idx_end;
        logic out_free;
    } t_sts;

    function automatic logic [BIN_BITS-1:0] classify(input logic [CHAR_BITS-1:0] c);
        logic [CHAR_BITS-1:0] d;
        if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            d = c - CH_UPPER_A;
        end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            d = c - CH_LOWER_A;
        end else if (c inside {[CH_ZERO:CH_NINE]}) begin
            d = c - CH_ZERO + CHAR_BITS'(DIGIT_BASE);
        end else begin
            d = CHAR_BITS'(OTHER_BIN);
        end
        return d[BIN_BITS-1:0];
    endfunction

endpackage

[rtl/chh_ctrl.sv]
// Controller state machine: accepts items and sequences the end-of-line drain.
module chh_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tlast,
    output logic          o_s_tready,
    input  chh_pkg::t_sts i_sts,
    output chh_pkg::t_cmd o_cmd
);

    chh_pkg::t_state r_state;
    chh_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = (r_state == chh_pkg::ST_IDLE);
        case (r_state)
            chh_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tlast) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = chh_pkg::ST_FLUSH;
                    end else begin
                        o_cmd.count = 1'b1;
                    end
                end
            end
            chh_pkg::ST_FLUSH: begin
                n_state = i_sts.any ? chh_pkg::ST_READ : chh_pkg::ST_EMPTY;
            end
            chh_pkg::ST_READ: begin
                o_cmd.sweep = 1'b1;
                n_state     = chh_pkg::ST_EMIT;
            end
            chh_pkg::ST_EMIT: begin
                o_cmd.sweep = 1'b1;
                if (!i_sts.bin_nz || i_sts.out_free) begin
                    o_cmd.load_bin = i_sts.bin_nz;
                    if (i_sts.idx_end) begin
                        n_state = chh_pkg::ST_CLEAR;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = chh_pkg::ST_READ;
                    end
                end
            end
            chh_pkg::ST_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.load_empty = 1'b1;
                    n_state          = chh_pkg::ST_CLEAR;
                end
            end
            chh_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = chh_pkg::ST_IDLE;
            end
            default: begin
                n_state = chh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/chh_dpath.sv]
// Datapath: bin counter memory, increment pipeline, drain index and output register.
module chh_dpath #(
    parameter int COUNT_BITS = chh_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [chh_pkg::CHAR_BITS-1:0]     i_char,
    input  chh_pkg::t_cmd                     i_cmd,
    output chh_pkg::t_sts                     o_sts,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [chh_pkg::M_TDATA_BITS-1:0]  o_m_tdata,
    output logic                              o_m_tlast,
    output logic                              o_m_tuser
);

    localparam int BB  = chh_pkg::BIN_BITS;
    localparam int OCB = chh_pkg::OUT_CNT_BITS;
    localparam int PAD = chh_pkg::M_TDATA_BITS - BB - OCB;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [COUNT_BITS-1:0]       r_mem [chh_pkg::NUM_BINS];
    logic [chh_pkg::NUM_BINS-1:0] r_bin_vld;
    logic [COUNT_BITS-1:0]       r_rd_data;
    logic                        r_rd_vld;
    logic                        r_fwd;
    logic [COUNT_BITS-1:0]       r_fwd_data;
    logic                        r_inc;
    logic [BB-1:0]               r_bin;
    logic                        r_any;
    logic [BB-1:0]               r_max;
    logic [BB-1:0]               r_idx;
    logic                        r_out_vld;
    logic [BB-1:0]               r_out_idx;
    logic [OCB-1:0]              r_out_cnt;
    logic                        r_out_last;
    logic                        r_out_empty;

    logic [BB-1:0]         bin_a;
    logic [BB-1:0]         rd_addr;
    logic [COUNT_BITS-1:0] cur;
    logic                  cur_nz;
    logic [COUNT_BITS-1:0] wr_data;
    logic [OCB-1:0]        rep_cnt;
    logic                  out_free;

    assign bin_a   = chh_pkg::classify(i_char);
    assign rd_addr = i_cmd.sweep ? r_idx : bin_a;
    assign cur_nz  = r_fwd || r_rd_vld;
    assign cur     = r_fwd ? r_fwd_data : (r_rd_vld ? r_rd_data : '0);
    assign wr_data = (cur == CNT_MAX) ? cur : cur + 1'b1;

    generate
        if (COUNT_BITS > OCB) begin : g_sat
            assign rep_cnt = (|cur[COUNT_BITS-1:OCB]) ? '1 : cur[OCB-1:0];
        end else begin : g_ext
            assign rep_cnt = OCB'(cur);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (r_inc) begin
            r_mem[r_bin] <= wr_data;
        end
        r_rd_data  <= r_mem[rd_addr];
        r_fwd_data <= wr_data;
        r_bin      <= bin_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_fwd     <= 1'b0;
            r_inc     <= 1'b0;
            r_any     <= 1'b0;
            r_max     <= '0;
            r_idx     <= '0;
        end else begin
            r_rd_vld <= r_bin_vld[rd_addr];
            r_fwd    <= r_inc && (r_bin == rd_addr);
            r_inc    <= i_cmd.count;
            if (i_cmd.clear) begin
                r_bin_vld <= '0;
                r_any     <= 1'b0;
                r_max     <= '0;
            end else begin
                if (r_inc) begin
                    r_bin_vld[r_bin] <= 1'b1;
                end
                if (i_cmd.count) begin
                    r_any <= 1'b1;
                    if (!r_any || (bin_a > r_max)) begin
                        r_max <= bin_a;
                    end
                end
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_bin || i_cmd.load_empty) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_bin) begin
            r_out_idx   <= r_idx;
            r_out_cnt   <= rep_cnt;
            r_out_last  <= (r_idx == r_max);
            r_out_empty <= 1'b0;
        end else if (i_cmd.load_empty) begin
            r_out_idx   <= '0;
            r_out_cnt   <= '0;
            r_out_last  <= 1'b1;
            r_out_empty <= 1'b1;
        end
    end

    assign o_sts.any      = r_any;
    assign o_sts.bin_nz   = cur_nz;
    assign o_sts.idx_end  = (r_idx == BB'(chh_pkg::NUM_BINS - 1));
    assign o_sts.out_free = out_free;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {PAD'(0), r_out_cnt, r_out_idx};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_empty;

endmodule

[rtl/character_class_histogram.sv]
// Character class histogram: 37 saturating bin counters drained on end of line.
// Character items: one accepted per cycle while idle, counted in the cycle after acceptance.
// End-of-line item: a flush state, then a memory read and an emit for each of all 37 bins,
// then a clear state; an empty line goes through the flush, empty and clear states.
// Output stalls lengthen the drain; no new item is accepted until it finishes.
// Synchronous active-low reset clears control and the per-bin valid bits.
module character_class_histogram #(
    parameter int COUNT_BITS = chh_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [chh_pkg::S_TDATA_BITS-1:0]  i_s_tdata,  // [7:0] char_code
    input  logic                              i_s_tlast,  // end_of_line
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [chh_pkg::M_TDATA_BITS-1:0]  o_m_tdata,  // [5:0] bin_index, [21:6] bin_count
    output logic                              o_m_tlast,  // last_of_run
    output logic                              o_m_tuser   // empty_line
);

    chh_pkg::t_cmd cmd;
    chh_pkg::t_sts sts;

    chh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    chh_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char     (i_s_tdata[chh_pkg::CHAR_BITS-1:0]),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

[rtl/chh_chk.sv]
// Port checker for the character class histogram and its bind.
module chh_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [chh_pkg::M_TDATA_BITS-1:0]  o_m_tdata,
    input logic                              o_m_tlast,
    input logic                              o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast && (o_m_tdata == '0))
        else $error("empty-line result not last or not zero");

    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> (o_m_tdata[21:6] != 16'd0))
        else $error("zero bin reported");

    a_drain_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("input taken during drain");

endmodule

bind character_class_histogram chh_chk u_chh_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
